// ===== design/paxy_pkg.sv =====
// Package for the polar angle unit: widths, special angles and arctangent table.
`default_nettype none

package paxy_pkg;

  // default configuration
  localparam int unsigned ITERATIONS_DEF  = 16;
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // fixed port and accumulator widths
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned TABLE_LEN = 32;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [ACC_W-1:0]   acc_t;

  // binary angles, full turn = 2^ANGLE_W
  localparam angle_t ANGLE_ZERO    = 16'h0000;
  localparam angle_t ANGLE_QUARTER = 16'h4000;
  localparam angle_t ANGLE_HALF    = 16'h8000;
  localparam angle_t ANGLE_3QUART  = 16'hC000;

  localparam acc_t ACC_HALF_TURN = 32'h8000_0000;
  localparam acc_t ACC_ROUND     = 32'h0000_8000;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic acc_t atan_entry(input logic [4:0] idx);
    acc_t r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/polar_angle_from_xy_unit.sv =====
// Throughput: one point per clock while in_stall_o is low; one stage for quadrant
// fold, one per CORDIC micro-rotation, one for rounding, passed in that order.
// Stages with no valid beat fill in under a stall.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
// Output register holds a beat under out_stall_i; beats behind it close up until full.
`default_nettype none

module polar_angle_from_xy_unit
  import paxy_pkg::*;
#(
  parameter int unsigned ITERATIONS  = ITERATIONS_DEF,
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PORT_W-1:0] x_coord_i,
  input  wire logic [PORT_W-1:0] y_coord_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ANGLE_W-1:0]     angle_o,
  output logic                   origin_flag_o
);

  // datapath wide enough for negation of the most negative value and CORDIC gain
  localparam int unsigned DW   = COORD_WIDTH + 2;
  localparam int unsigned LAST = ITERATIONS;     // last CORDIC stage index
  localparam int unsigned OUTS = ITERATIONS + 1; // output stage index

  typedef logic signed [DW-1:0] coord_t;

  // per-stage valid and advance
  logic            v_q   [0:OUTS];
  logic            adv   [0:OUTS];

  // CORDIC stage payload
  coord_t          x_q   [0:LAST];
  coord_t          y_q   [0:LAST];
  acc_t            acc_q [0:LAST];
  logic            spec_q[0:LAST];
  angle_t          fix_q [0:LAST];
  logic            orig_q[0:LAST];

  // output register
  angle_t          angle_q;
  logic            origin_q;

  // advance chain: a stage moves when empty or when its successor moves
  assign adv[OUTS] = !v_q[OUTS] || !out_stall_i;
  for (genvar k = 0; k < OUTS; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign in_stall_o = !adv[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= OUTS; k++) v_q[k] <= 1'b0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= OUTS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // input fold: sign-extend, detect axis cases, rotate left half plane by a half turn
  logic [ACC_W-1:0] xz, yz;
  coord_t           x_in, y_in;
  logic             x_zero, y_zero, x_neg, y_neg;
  angle_t           fix_d;

  assign xz    = ACC_W'(x_coord_i);
  assign yz    = ACC_W'(y_coord_i);
  assign x_in  = DW'($signed(xz[COORD_WIDTH-1:0]));
  assign y_in  = DW'($signed(yz[COORD_WIDTH-1:0]));
  assign x_zero = (x_in == '0);
  assign y_zero = (y_in == '0);
  assign x_neg  = x_in[DW-1];
  assign y_neg  = y_in[DW-1];

  always_comb begin
    fix_d = ANGLE_ZERO;
    if (x_zero && !y_zero) begin
      fix_d = y_neg ? ANGLE_3QUART : ANGLE_QUARTER;
    end else if (y_zero && x_neg) begin
      fix_d = ANGLE_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      x_q[0]    <= x_neg ? -x_in : x_in;
      y_q[0]    <= x_neg ? -y_in : y_in;
      acc_q[0]  <= x_neg ? ACC_HALF_TURN : '0;
      spec_q[0] <= x_zero || y_zero;
      fix_q[0]  <= fix_d;
      orig_q[0] <= x_zero && y_zero;
    end
  end

  // one micro-rotation per stage, driving y toward zero
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    coord_t xs, ys;
    acc_t   at;
    logic   y_pos;

    assign xs    = x_q[k] >>> k;
    assign ys    = y_q[k] >>> k;
    assign at    = atan_entry(5'(k));
    assign y_pos = !y_q[k][DW-1];

    always_ff @(posedge clk_i) begin
      if (adv[k+1] && v_q[k]) begin
        x_q[k+1]    <= y_pos ? x_q[k] + ys : x_q[k] - ys;
        y_q[k+1]    <= y_pos ? y_q[k] - xs : y_q[k] + xs;
        acc_q[k+1]  <= y_pos ? acc_q[k] + at : acc_q[k] - at;
        spec_q[k+1] <= spec_q[k];
        fix_q[k+1]  <= fix_q[k];
        orig_q[k+1] <= orig_q[k];
      end
    end
  end

  // round to output width, or take the fixed axis angle
  acc_t acc_rnd;
  assign acc_rnd = acc_q[LAST] + ACC_ROUND;

  always_ff @(posedge clk_i) begin
    if (adv[OUTS] && v_q[LAST]) begin
      angle_q  <= spec_q[LAST] ? fix_q[LAST] : acc_rnd[ACC_W-1 -: ANGLE_W];
      origin_q <= orig_q[LAST];
    end
  end

  assign out_valid_o   = v_q[OUTS];
  assign angle_o       = angle_q;
  assign origin_flag_o = origin_q;

endmodule

`default_nettype wire
